// ===== rtl/brel_pkg.sv =====
// brel_pkg: shared types and constants of the branch relocator
// no dependencies; imported by the interfaces and every module of the block
package brel_pkg;

  localparam int FIELD_ADDR_W = 64;   // width of the address fields on the ports
  localparam int WORD_W       = 32;   // width of instruction and flag words
  localparam int ADDR_W_DEF   = 64;   // default active address width

  // operation codes carried in the command field
  typedef enum logic [1:0] {
    CMD_TRANSLATE = 2'd0,
    CMD_CREATE_I  = 2'd1,
    CMD_CREATE_B  = 2'd2,
    CMD_INSPECT   = 2'd3
  } brel_cmd_t;

  // primary opcodes
  localparam logic [5:0] OPC_IFORM = 6'd18;
  localparam logic [5:0] OPC_BFORM = 6'd16;

  // bit positions inside a branch word
  localparam int AA_BIT = 1;

  // decoded attributes of one instruction word
  typedef struct packed {
    logic is_branch;
    logic is_iform;
    logic is_relative;
  } brel_dec_t;

endpackage

// ===== rtl/brel_req_if.sv =====
// brel_req_if: request channel of the branch relocator, valid/ready plus payload
// depends on brel_pkg
interface brel_req_if
  import brel_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic [WORD_W-1:0]       instr_word;
  logic [FIELD_ADDR_W-1:0] instr_addr;
  logic [FIELD_ADDR_W-1:0] new_addr;
  logic [FIELD_ADDR_W-1:0] target_addr;
  logic [WORD_W-1:0]       flags;

  modport source (
    output valid, command, instr_word, instr_addr, new_addr, target_addr, flags,
    input  ready
  );
  modport sink (
    input  valid, command, instr_word, instr_addr, new_addr, target_addr, flags,
    output ready
  );
endinterface

// ===== rtl/brel_rsp_if.sv =====
// brel_rsp_if: result channel of the branch relocator, valid/ready plus payload
// depends on brel_pkg
interface brel_rsp_if
  import brel_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [WORD_W-1:0]       out_word;
  logic [FIELD_ADDR_W-1:0] out_target;
  logic                    ok;
  logic                    is_branch;
  logic                    is_relative;
  logic                    target_match;

  modport source (
    output valid, out_word, out_target, ok, is_branch, is_relative, target_match,
    input  ready
  );
  modport sink (
    input  valid, out_word, out_target, ok, is_branch, is_relative, target_match,
    output ready
  );
endinterface

// ===== rtl/branch_instruction_relocator.sv =====
// branch_instruction_relocator: PowerPC branch translate / create / inspect unit
// depends on brel_pkg, brel_req_if, brel_rsp_if, brel_decode, brel_encode
// path: request through the input, decode and result registers (3 regs) to the response
// throughput: one transaction per cycle, stalls only when the result side holds off
// reset: synchronous active-high rst clears the stage valid bits and holds ready low
// the pipeline has no other state, so the block is ready as soon as rst drops
module branch_instruction_relocator
  import brel_pkg::*;
#(
  parameter int ADDR_W = ADDR_W_DEF   // active address width, 32 to 64
) (
  input logic       clk,
  input logic       rst,
  brel_req_if.sink   request,
  brel_rsp_if.source response
);

  // stage advance: a stage loads when it is empty or its content moves on
  logic adv1;
  logic adv2;
  logic adv3;

  // stage 1: captured request, addresses trimmed to the active width
  logic              v1;
  brel_cmd_t         cmd1;
  logic [WORD_W-1:0] word1;
  logic [ADDR_W-1:0] src1;
  logic [ADDR_W-1:0] dst1;
  logic [ADDR_W-1:0] tgt1;
  logic [WORD_W-1:0] flags1;

  // stage 2: decoded word plus operands for the encoder
  logic              v2;
  brel_cmd_t         cmd2;
  logic [WORD_W-1:0] word2;
  logic [ADDR_W-1:0] dst2;
  logic [ADDR_W-1:0] tgt2;
  logic [WORD_W-1:0] flags2;
  logic [ADDR_W-1:0] dect2;
  brel_dec_t         dec2;

  // stage 3: result register
  logic              v3;
  logic [WORD_W-1:0] word3;
  logic [ADDR_W-1:0] dect3;
  logic              ok3;
  logic              br3;
  logic              rel3;
  logic              match3;

  // combinational results
  logic [ADDR_W-1:0] dec_target;
  brel_dec_t         dec;
  logic [WORD_W-1:0] enc_word;
  logic              enc_ok;

  assign adv3 = !v3 || response.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  // no request transaction while reset is held
  assign request.ready = adv1 && !rst;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= request.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // input register: take a request transaction
  always_ff @(posedge clk) begin
    if (adv1 && request.valid) begin
      cmd1   <= brel_cmd_t'(request.command);
      word1  <= request.instr_word;
      src1   <= request.instr_addr[ADDR_W-1:0];
      dst1   <= request.new_addr[ADDR_W-1:0];
      tgt1   <= request.target_addr[ADDR_W-1:0];
      flags1 <= request.flags;
    end
  end

  // decode the existing word at its current address
  brel_decode #(.ADDR_W(ADDR_W)) u_decode (
    .word   (word1),
    .at     (src1),
    .target (dec_target),
    .dec    (dec)
  );

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      cmd2   <= cmd1;
      word2  <= word1;
      dst2   <= dst1;
      tgt2   <= tgt1;
      flags2 <= flags1;
      dect2  <= dec_target;
      dec2   <= dec;
    end
  end

  // encode the branch for the selected operation at the new address
  brel_encode #(.ADDR_W(ADDR_W)) u_encode (
    .cmd        (cmd2),
    .word       (word2),
    .dec        (dec2),
    .dec_target (dect2),
    .at         (dst2),
    .tgt        (tgt2),
    .flags      (flags2),
    .enc_word   (enc_word),
    .ok         (enc_ok)
  );

  // result register; target compare sits here beside the encoder
  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      word3  <= enc_word;
      dect3  <= dect2;
      ok3    <= enc_ok;
      br3    <= dec2.is_branch;
      rel3   <= dec2.is_relative;
      match3 <= dec2.is_branch && (dect2 == tgt2);
    end
  end

  assign response.valid        = v3;
  assign response.out_word     = word3;
  assign response.out_target   = FIELD_ADDR_W'(dect3);
  assign response.ok           = ok3;
  assign response.is_branch    = br3;
  assign response.is_relative  = rel3;
  assign response.target_match = match3;

  // a produced word always means success
  a_word_implies_ok: assert property (@(posedge clk) disable iff (rst)
    v3 && (word3 != '0) |-> ok3)
    else $error("nonzero result word without ok");

  // a produced word is always an I-form or B-form branch
  a_word_is_branch: assert property (@(posedge clk) disable iff (rst)
    v3 && (word3 != '0) |-> (word3[31:26] == OPC_IFORM) || (word3[31:26] == OPC_BFORM))
    else $error("result word has a non-branch opcode");

  // a word that is not a branch carries no decode results
  a_nonbranch_clear: assert property (@(posedge clk) disable iff (rst)
    v3 && !br3 |-> (dect3 == '0) && !rel3 && !match3)
    else $error("decode results set for a non-branch word");

  // the decode register feeds the result register in order
  a_stage_flow: assert property (@(posedge clk) disable iff (rst)
    v2 && adv3 |=> v3)
    else $error("result lost between decode and result stage");

endmodule

// ===== rtl/brel_decode.sv =====
// brel_decode: classifies an instruction word and computes its branch target
// depends on brel_pkg
module brel_decode
  import brel_pkg::*;
#(
  parameter int ADDR_W = ADDR_W_DEF
) (
  input  logic [WORD_W-1:0] word,
  input  logic [ADDR_W-1:0] at,
  output logic [ADDR_W-1:0] target,
  output brel_dec_t         dec
);
  logic [5:0]        opc;
  logic [ADDR_W-1:0] imm;

  assign opc = word[31:26];

  always_comb begin
    dec.is_iform    = (opc == OPC_IFORM);
    dec.is_branch   = dec.is_iform || (opc == OPC_BFORM);
    dec.is_relative = dec.is_branch && !word[AA_BIT];
    // sign-extended immediate of the detected form
    if (dec.is_iform) begin
      imm = {{(ADDR_W-26){word[25]}}, word[25:2], 2'b00};
    end else begin
      imm = {{(ADDR_W-16){word[15]}}, word[15:2], 2'b00};
    end
    if (!dec.is_branch) begin
      target = '0;
    end else if (dec.is_relative) begin
      target = imm + at;
    end else begin
      target = imm;
    end
  end
endmodule

// ===== rtl/brel_encode.sv =====
// brel_encode: builds an I-form or B-form branch word for the selected operation
// depends on brel_pkg
module brel_encode
  import brel_pkg::*;
#(
  parameter int ADDR_W = ADDR_W_DEF
) (
  input  brel_cmd_t         cmd,
  input  logic [WORD_W-1:0] word,
  input  brel_dec_t         dec,
  input  logic [ADDR_W-1:0] dec_target,
  input  logic [ADDR_W-1:0] at,
  input  logic [ADDR_W-1:0] tgt,
  input  logic [WORD_W-1:0] flags,
  output logic [WORD_W-1:0] enc_word,
  output logic              ok
);
  logic [ADDR_W-1:0] dest;
  logic [WORD_W-1:0] fl;
  logic              want_i;
  logic              want_b;
  logic [ADDR_W-1:0] disp;
  logic              fit_i;
  logic              fit_b;
  logic              aligned;

  // operand selection per operation
  always_comb begin
    dest   = tgt;
    fl     = flags;
    want_i = 1'b0;
    want_b = 1'b0;
    unique case (cmd)
      CMD_TRANSLATE: begin
        dest   = dec_target;
        fl     = word;
        want_i = dec.is_branch && dec.is_iform;
        want_b = dec.is_branch && !dec.is_iform;
      end
      CMD_CREATE_I: want_i = 1'b1;
      CMD_CREATE_B: want_b = 1'b1;
      CMD_INSPECT: begin
        want_i = 1'b0;
        want_b = 1'b0;
      end
      default: begin
        want_i = 1'b0;
        want_b = 1'b0;
      end
    endcase
  end

  // absolute keeps the target itself, relative takes the wrapped difference
  assign disp    = fl[AA_BIT] ? dest : dest - at;
  assign aligned = (disp[1:0] == 2'b00);
  // displacement fits in a signed 26-bit or 16-bit field
  assign fit_i   = (&disp[ADDR_W-1:25]) || !(|disp[ADDR_W-1:25]);
  assign fit_b   = (&disp[ADDR_W-1:15]) || !(|disp[ADDR_W-1:15]);

  always_comb begin
    enc_word = '0;
    ok       = 1'b0;
    if (cmd == CMD_INSPECT) begin
      ok = dec.is_branch;
    end else if (want_i && fit_i && aligned) begin
      enc_word = {OPC_IFORM, disp[25:2], fl[1:0]};
      ok       = 1'b1;
    end else if (want_b && fit_b && aligned) begin
      enc_word = {OPC_BFORM, fl[25:16], disp[15:2], fl[1:0]};
      ok       = 1'b1;
    end
  end
endmodule
